>>> hdl/assert_macros.svh
// Assertion helpers for the heap design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked every clock outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Types and constants shared by the indexed min-heap modules.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned KEY_W     = 8;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned KEY_COUNT = 256;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] weight;
    logic [7:0]         key_id;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] top_weight;
    logic [7:0]         top_key;
    logic [8:0]         entry_count;
    logic               is_empty;
    logic               pop_error;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS_RD,
    ST_POS_WAIT,
    ST_CLASSIFY,
    ST_POP_RD,
    ST_POP_WAIT,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_PLACE,
    ST_ROOT_RD,
    ST_ROOT_WAIT,
    ST_DONE
  } exec_state_t;

endpackage

>>> hdl/imh_ram.sv
// ----------------------------------------------------------------------------
// imh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/imh_front.sv
// ----------------------------------------------------------------------------
// imh_front
// Input stage: takes requests and holds them in a two-entry queue for the
// heap engine.
// ----------------------------------------------------------------------------
module imh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  imh_pkg::in_req_t  in_data,
  output logic              q_valid,
  output imh_pkg::in_req_t  q_data,
  input  logic              q_take
);

  imh_pkg::in_req_t slot_r [2];
  logic             rd_ptr_r, rd_ptr_nxt;
  logic             wr_ptr_r, wr_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_data   = slot_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

>>> hdl/imh_engine.sv
// ----------------------------------------------------------------------------
// imh_engine
// Heap engine: carries out push, update and pop with a sift loop over the
// slot and position memories, one heap level per pass of its read and compare states.
// ----------------------------------------------------------------------------
module imh_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  imh_pkg::in_req_t  q_data,
  output logic              q_take,
  output logic              out_valid,
  input  logic              out_stall,
  output imh_pkg::out_req_t out_data,
  output logic [imh_pkg::COUNT_W-1:0] count_mon
);

  localparam int unsigned AW = $clog2(imh_pkg::KEY_COUNT);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned EW = 32 + 8;

  imh_pkg::exec_state_t state_r, state_nxt;

  // memories: slot entries {weight,key}, position map
  logic          s_we;
  logic [AW-1:0] s_wa, s_ra;
  logic [EW-1:0] s_wd, s_rd;
  logic          p_we;
  logic [AW-1:0] p_wa, p_ra;
  logic [AW-1:0] p_wd, p_rd;

  imh_ram #(.WIDTH(EW), .DEPTH(imh_pkg::KEY_COUNT)) u_slot (
    .clk(clk), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
    .rd_addr(s_ra), .rd_data(s_rd)
  );
  imh_ram #(.WIDTH(AW), .DEPTH(imh_pkg::KEY_COUNT)) u_pos (
    .clk(clk), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
    .rd_addr(p_ra), .rd_data(p_rd)
  );

  logic [imh_pkg::KEY_COUNT-1:0] kvalid_r, kvalid_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic                 act_r, act_nxt;
  logic signed [31:0]   w_r, w_nxt;
  logic [7:0]           k_r, k_nxt;
  logic [AW-1:0]        key_ix;
  logic [CW-1:0]        pos_r, pos_nxt;     // current hole
  logic [CW-1:0]        nb_r, nb_nxt;       // parent or child being read
  logic signed [31:0]   lw_r, lw_nxt;       // left child
  logic [7:0]           lk_r, lk_nxt;
  logic                 lhave_r, lhave_nxt;
  logic                 perr_r, perr_nxt;
  imh_pkg::out_req_t    res_r, res_nxt;
  logic                 res_v_r, res_v_nxt;
  logic                 key_ok;
  logic signed [31:0]   rd_w;
  logic [7:0]           rd_k;
  logic [CW-1:0]        lc, parent;

  assign rd_w      = s_rd[EW-1:8];
  assign rd_k      = s_rd[7:0];
  assign key_ix    = k_r[AW-1:0];
  assign key_ok    = ({{(CW > 8 ? CW-8 : 1){1'b0}}, k_r} < imh_pkg::KEY_COUNT);
  assign lc        = {pos_r[CW-2:0], 1'b1};
  assign parent    = (pos_r - 1'b1) >> 1;
  assign out_valid = res_v_r;
  assign out_data  = res_r;
  assign count_mon = fill_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      imh_pkg::ST_IDLE:     if (q_valid && !res_v_r) state_nxt = imh_pkg::ST_POS_RD;
      imh_pkg::ST_POS_RD: begin
        if (act_r == imh_pkg::ACT_POP) begin
          state_nxt = (fill_r == '0) ? imh_pkg::ST_ROOT_RD : imh_pkg::ST_POP_RD;
        end else if (!key_ok) begin
          state_nxt = imh_pkg::ST_ROOT_RD;
        end else if (!kvalid_r[key_ix]) begin
          state_nxt = imh_pkg::ST_UP_RD;
        end else begin
          state_nxt = imh_pkg::ST_POS_WAIT;
        end
      end
      imh_pkg::ST_POS_WAIT: state_nxt = imh_pkg::ST_CLASSIFY;
      imh_pkg::ST_CLASSIFY: begin
        if (w_r == rd_w) state_nxt = imh_pkg::ST_ROOT_RD;
        else if (w_r < rd_w) state_nxt = imh_pkg::ST_UP_RD;
        else state_nxt = imh_pkg::ST_DN_RD;
      end
      imh_pkg::ST_POP_RD:   state_nxt = imh_pkg::ST_POP_WAIT;
      imh_pkg::ST_POP_WAIT: begin
        state_nxt = (fill_r == '0) ? imh_pkg::ST_ROOT_RD : imh_pkg::ST_DN_RD;
      end
      imh_pkg::ST_UP_RD: begin
        state_nxt = (pos_r == '0) ? imh_pkg::ST_PLACE : imh_pkg::ST_UP_CMP;
      end
      imh_pkg::ST_UP_CMP: begin
        state_nxt = (w_r < rd_w) ? imh_pkg::ST_UP_RD : imh_pkg::ST_PLACE;
      end
      imh_pkg::ST_DN_RD: begin
        if (lc >= fill_r) state_nxt = imh_pkg::ST_PLACE;
        else state_nxt = imh_pkg::ST_DN_CMP;
      end
      imh_pkg::ST_DN_CMP: begin
        if (!lhave_r && (lc + 1'b1 < fill_r)) state_nxt = imh_pkg::ST_DN_CMP;
        else if ((lhave_r && rd_w < lw_r ? rd_w : (lhave_r ? lw_r : rd_w)) < w_r)
          state_nxt = imh_pkg::ST_DN_RD;
        else state_nxt = imh_pkg::ST_PLACE;
      end
      imh_pkg::ST_PLACE:     state_nxt = imh_pkg::ST_ROOT_RD;
      imh_pkg::ST_ROOT_RD:   state_nxt = imh_pkg::ST_ROOT_WAIT;
      imh_pkg::ST_ROOT_WAIT: state_nxt = imh_pkg::ST_DONE;
      imh_pkg::ST_DONE:      state_nxt = imh_pkg::ST_IDLE;
      default:               state_nxt = imh_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    logic               pick_r;
    logic signed [31:0] mw;
    logic [7:0]         mk;
    logic [CW-1:0]      mpos;
    pick_r     = 1'b0;
    mw         = '0;
    mk         = '0;
    mpos       = '0;
    s_we       = 1'b0;
    s_wa       = pos_r[AW-1:0];
    s_wd       = {w_r, k_r};
    s_ra       = pos_r[AW-1:0];
    p_we       = 1'b0;
    p_wa       = key_ix;
    p_wd       = pos_r[AW-1:0];
    p_ra       = key_ix;
    kvalid_nxt = kvalid_r;
    fill_nxt   = fill_r;
    act_nxt    = act_r;
    w_nxt      = w_r;
    k_nxt      = k_r;
    pos_nxt    = pos_r;
    nb_nxt     = nb_r;
    lw_nxt     = lw_r;
    lk_nxt     = lk_r;
    lhave_nxt  = lhave_r;
    perr_nxt   = perr_r;
    res_nxt    = res_r;
    res_v_nxt  = res_v_r && out_stall;
    q_take     = 1'b0;
    case (state_r)
      imh_pkg::ST_IDLE: begin
        if (q_valid && !res_v_r) begin
          q_take   = 1'b1;
          act_nxt  = q_data.action;
          w_nxt    = q_data.weight;
          k_nxt    = q_data.key_id;
          perr_nxt = 1'b0;
        end
      end
      imh_pkg::ST_POS_RD: begin
        if (act_r == imh_pkg::ACT_POP) begin
          if (fill_r == '0) perr_nxt = 1'b1;
          s_ra = '0;
        end else if (key_ok && !kvalid_r[key_ix]) begin
          pos_nxt            = fill_r;
          fill_nxt           = fill_r + 1'b1;
          kvalid_nxt[key_ix] = 1'b1;
        end
      end
      imh_pkg::ST_POS_WAIT: begin
        s_ra = p_rd;
        pos_nxt = {1'b0, p_rd};
      end
      imh_pkg::ST_CLASSIFY: ;
      imh_pkg::ST_POP_RD: begin
        // s_rd holds the root; fetch the last slot
        kvalid_nxt[rd_k[AW-1:0]] = 1'b0;
        fill_nxt = fill_r - 1'b1;
        s_ra     = fill_nxt[AW-1:0];
        pos_nxt  = '0;
      end
      imh_pkg::ST_POP_WAIT: begin
        w_nxt = rd_w;
        k_nxt = rd_k;
      end
      imh_pkg::ST_UP_RD: begin
        s_ra  = parent[AW-1:0];
        nb_nxt = parent;
      end
      imh_pkg::ST_UP_CMP: begin
        if (w_r < rd_w) begin
          s_we = 1'b1;
          s_wd = s_rd;
          p_we = 1'b1;
          p_wa = rd_k[AW-1:0];
          pos_nxt = nb_r;
        end
      end
      imh_pkg::ST_DN_RD: begin
        s_ra      = lc[AW-1:0];
        nb_nxt    = lc;
        lhave_nxt = 1'b0;
      end
      imh_pkg::ST_DN_CMP: begin
        if (!lhave_r && (lc + 1'b1 < fill_r)) begin
          lw_nxt    = rd_w;
          lk_nxt    = rd_k;
          lhave_nxt = 1'b1;
          s_ra      = lc[AW-1:0] + 1'b1;
        end else begin
          if (lhave_r && rd_w < lw_r) begin
            pick_r = 1'b1;
            mw = rd_w;
            mk = rd_k;
          end else if (lhave_r) begin
            mw = lw_r;
            mk = lk_r;
          end else begin
            mw = rd_w;
            mk = rd_k;
          end
          mpos = pick_r ? lc + 1'b1 : lc;
          if (mw < w_r) begin
            s_we    = 1'b1;
            s_wd    = {mw, mk};
            p_we    = 1'b1;
            p_wa    = mk[AW-1:0];
            pos_nxt = mpos;
          end
        end
      end
      imh_pkg::ST_PLACE: begin
        s_we = 1'b1;
        p_we = 1'b1;
      end
      imh_pkg::ST_ROOT_RD:   s_ra = '0;
      imh_pkg::ST_ROOT_WAIT: s_ra = '0;
      imh_pkg::ST_DONE: begin
        res_v_nxt           = 1'b1;
        res_nxt.entry_count = fill_r;
        res_nxt.is_empty    = (fill_r == '0);
        res_nxt.pop_error   = perr_r;
        res_nxt.top_weight  = (fill_r == '0) ? '0 : rd_w;
        res_nxt.top_key     = (fill_r == '0) ? '0 : rd_k;
      end
      default: ;
    endcase
  end

  // root read issued in ST_ROOT_RD lands in ROOT_WAIT; ROOT_WAIT re-reads it for DONE
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= imh_pkg::ST_IDLE;
      kvalid_r <= '0;
      fill_r   <= '0;
      res_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      kvalid_r <= kvalid_nxt;
      fill_r   <= fill_nxt;
      res_v_r  <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    w_r     <= w_nxt;
    k_r     <= k_nxt;
    pos_r   <= pos_nxt;
    nb_r    <= nb_nxt;
    lw_r    <= lw_nxt;
    lk_r    <= lk_nxt;
    lhave_r <= lhave_nxt;
    perr_r  <= perr_nxt;
    res_r   <= res_nxt;
  end

endmodule

>>> hdl/indexed_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap priority queue with a key-to-slot position map.
// ----------------------------------------------------------------------------
// One request is in flight at a time. The time a request takes from the queue
// to its result grows with each level of sift-up or sift-down; the sift loop
// through the slot memory and its one read port sets it. A two-entry request
// queue in front lets the producer run ahead; the result register lets a
// request start only once the prior result was taken. No clearing pass is
// needed after reset.
`include "assert_macros.svh"

module indexed_min_heap (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  imh_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output imh_pkg::out_req_t out_data
);

  logic                         q_valid, q_take;
  imh_pkg::in_req_t             q_data;
  logic [imh_pkg::COUNT_W-1:0]  count_mon;

  imh_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_data(q_data), .q_take(q_take)
  );

  imh_engine u_engine (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
    .q_take(q_take), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .count_mon(count_mon)
  );

  `ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_mon <= imh_pkg::KEY_COUNT, "count overflow")
  `ASSERT_IMPL(a_empty_flag, clk, rst_n, out_valid,
    out_data.is_empty == (out_data.entry_count == '0), "empty flag mismatch")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `ASSERT_IMPL(a_take_valid, clk, rst_n, q_take, q_valid && !out_valid, "take without room")

endmodule

>>> test/indexed_min_heap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_tb
// Drives pushes, weight updates and pops into the indexed min-heap and checks
// every result against a heap kept inside the bench, under random gaps on the
// request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module indexed_min_heap_tb;

  localparam int KEYS = 256;
  localparam int CYCLE_LIMIT = 1000000;

  class heap_board;
    logic signed [31:0]        hw[KEYS];
    logic [7:0]                hk[KEYS];
    int                        slot_of[KEYS];
    bit                        held[KEYS];
    int                        count;
    imh_pkg::out_req_t         pending[$];
    int                        errors;

    function new();
      count = 0;
      errors = 0;
      foreach (held[i]) held[i] = 0;
    endfunction

    function void put(int p, logic signed [31:0] w, logic [7:0] k);
      hw[p] = w;
      hk[p] = k;
      slot_of[k] = p;
      held[k] = 1;
    endfunction

    function void raise(int p);
      logic signed [31:0] w;
      logic [7:0] k;
      int up;
      w = hw[p];
      k = hk[p];
      while (p != 0) begin
        up = (p - 1) / 2;
        if (!(w < hw[up])) break;
        put(p, hw[up], hk[up]);
        p = up;
      end
      put(p, w, k);
    endfunction

    function void lower(int p);
      logic signed [31:0] w;
      logic [7:0] k;
      int lc;
      int pick;
      w = hw[p];
      k = hk[p];
      forever begin
        lc = 2 * p + 1;
        if (lc >= count) break;
        pick = (lc + 1 < count && hw[lc + 1] < hw[lc]) ? lc + 1 : lc;
        if (!(hw[pick] < w)) break;
        put(p, hw[pick], hk[pick]);
        p = pick;
      end
      put(p, w, k);
    endfunction

    // Apply one accepted request and queue the root it leaves behind.
    function void note_request(imh_pkg::in_req_t r);
      imh_pkg::out_req_t res;
      int p;
      res = '0;
      if (r.action == imh_pkg::ACT_PUSH) begin
        if (!held[r.key_id]) begin
          put(count, r.weight, r.key_id);
          count++;
          raise(count - 1);
        end else begin
          p = slot_of[r.key_id];
          if (r.weight < hw[p]) begin
            hw[p] = r.weight;
            raise(p);
          end else if (r.weight > hw[p]) begin
            hw[p] = r.weight;
            lower(p);
          end
        end
      end else if (count == 0) begin
        res.pop_error = 1'b1;
      end else begin
        held[hk[0]] = 0;
        count--;
        if (count > 0) begin
          put(0, hw[count], hk[count]);
          lower(0);
        end
      end
      if (count == 0) begin
        res.is_empty = 1'b1;
      end else begin
        res.top_weight = hw[0];
        res.top_key = hk[0];
      end
      res.entry_count = count[8:0];
      pending.push_back(res);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(imh_pkg::out_req_t got);
      imh_pkg::out_req_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = pending.pop_front();
        if (got.top_weight !== want.top_weight)
          report("top_weight", got.top_weight, want.top_weight);
        if (got.top_key !== want.top_key) report("top_key", got.top_key, want.top_key);
        if (got.entry_count !== want.entry_count)
          report("entry_count", got.entry_count, want.entry_count);
        if (got.is_empty !== want.is_empty) report("is_empty", got.is_empty, want.is_empty);
        if (got.pop_error !== want.pop_error)
          report("pop_error", got.pop_error, want.pop_error);
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  imh_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  imh_pkg::out_req_t out_data;

  heap_board board = new();
  int        cycles = 0;
  int        burst_left = 0;
  bit        stall_mode = 0;

  indexed_min_heap uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("indexed_min_heap verification failed");
      $finish;
    end
  end

  // Result side: check accepted results, then pick the stall for next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    if (stall_mode) out_stall <= ($urandom_range(0, 3) != 0);
    else out_stall <= ($urandom_range(0, 9) == 0);
  end

  // Hold one request until accepted; the gap comes before it. Valid stays
  // high after acceptance until the next request, a gap or drain() replaces it.
  task send(bit act, logic signed [31:0] w, logic [7:0] k);
    imh_pkg::in_req_t r;
    int gap;
    r.action = act;
    r.weight = w;
    r.key_id = k;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(r);
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function logic signed [31:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(0, 15)) - 32'd8);
      default: return $signed($urandom);
    endcase
  endfunction

  function logic [7:0] pick_key(int span);
    return 8'($urandom_range(0, span));
  endfunction

  initial begin
    int span;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pop, extremes, update up/down/equal, pop to empty
    send(imh_pkg::ACT_POP, 32'sd5, 8'd3);
    send(imh_pkg::ACT_PUSH, 32'sh7fff_ffff, 8'd255);
    send(imh_pkg::ACT_PUSH, 32'sh8000_0000, 8'd0);
    send(imh_pkg::ACT_PUSH, 32'sd0, 8'd128);
    send(imh_pkg::ACT_PUSH, -32'sd1, 8'd127);
    send(imh_pkg::ACT_PUSH, 32'sh7fff_fffe, 8'd0);
    send(imh_pkg::ACT_PUSH, 32'sh8000_0000, 8'd255);
    send(imh_pkg::ACT_PUSH, 32'sh8000_0000, 8'd255);
    send(imh_pkg::ACT_PUSH, 32'sd0, 8'd127);
    repeat (5) send(imh_pkg::ACT_POP, 32'shffff_ffff, 8'hff);
    send(imh_pkg::ACT_PUSH, 32'sd7, 8'hAA);
    send(imh_pkg::ACT_PUSH, 32'sd7, 8'h55);
    send(imh_pkg::ACT_POP, 32'sd0, 8'd0);
    send(imh_pkg::ACT_POP, 32'sd0, 8'd0);
    send(imh_pkg::ACT_POP, 32'sd0, 8'd0);
    drain();

    // random: phases with different key spans and pop rates
    for (int ph = 0; ph < 7; ph++) begin
      span = (ph == 3) ? 255 : ((ph % 2) ? 15 : 63);
      for (int i = 0; i < 250; i++) begin
        if (ph == 3 && i < 200) send(imh_pkg::ACT_PUSH, pick_weight(), pick_key(span));
        else if ($urandom_range(0, 9) < ((ph == 5) ? 7 : 4))
          send(imh_pkg::ACT_POP, $signed($urandom), 8'($urandom));
        else send(imh_pkg::ACT_PUSH, pick_weight(), pick_key(span));
      end
      if (ph == 2) drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("indexed_min_heap verification clean");
    else
      $display("indexed_min_heap verification failed");
    $finish;
  end
endmodule
